### rtl/ifsd_pkg.sv
// Shared types and constants for the IMU frame sync decoder.
package ifsd_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACC  = 8'h51;
    localparam logic [7:0] TYPE_GYRO = 8'h52;

    // Byte positions within a frame
    localparam logic [3:0] POS_HUNT      = 4'd0;
    localparam logic [3:0] POS_TYPE      = 4'd1;
    localparam logic [3:0] POS_PAY_FIRST = 4'd2;
    localparam logic [3:0] POS_LAST      = 4'd10;

    localparam int PAY_BYTES = 8;
    localparam int PAY_IDX_W = $clog2(PAY_BYTES);
    localparam int RAW_W     = 16;
    localparam int OUT_W     = 17;
    localparam int PROD_W    = 33;
    localparam int TPROD_W   = 39;

    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_GYRO = 1'b1;

    // Axis scaling: raw * mult, then arithmetic shift (floor)
    localparam logic signed [OUT_W-1:0] ACC_MULT  = 17'sd40141;
    localparam logic signed [OUT_W-1:0] GYRO_MULT = 17'sd125;
    localparam int ACC_SHIFT  = 15;
    localparam int GYRO_SHIFT = 3;
    localparam logic signed [PROD_W-1:0] AXIS_LIM = 33'sd64000;

    // Temperature: |raw| * 64 / 85 via reciprocal ceil(2^29 / 85), shift 29 - 6
    localparam logic [22:0] TEMP_RECIP = 23'd6316129;
    localparam int TEMP_SHIFT = 23;
    localparam logic signed [OUT_W-1:0] TEMP_OFS = 17'sd9280;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic                    kind;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
        logic signed [RAW_W-1:0] raw_t;
    } frame_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

### rtl/ifsd_front.sv
// Byte parser: header hunt, type check and payload collection.
module ifsd_front import ifsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  q_status_t  q_status,
    output logic       push,
    output frame_t     push_frame
);

    logic [3:0] pos_reg, pos_next, pos_eff;
    logic       kind_reg, kind_next;
    logic [7:0] pay_reg [PAY_BYTES];
    logic       accept;
    logic [PAY_IDX_W-1:0] pay_idx;

    assign pos_eff  = (pos_reg > POS_LAST) ? POS_HUNT : pos_reg;
    // Stall only on the final byte while the queue has no room
    assign s_tready = (pos_eff != POS_LAST) || !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (pos_eff == POS_LAST);
    assign pay_idx  = PAY_IDX_W'(pos_eff - POS_PAY_FIRST);

    assign push_frame.kind  = kind_reg;
    assign push_frame.raw_x = {pay_reg[1], pay_reg[0]};
    assign push_frame.raw_y = {pay_reg[3], pay_reg[2]};
    assign push_frame.raw_z = {pay_reg[5], pay_reg[4]};
    assign push_frame.raw_t = {pay_reg[7], pay_reg[6]};

    always_comb begin
        pos_next  = pos_reg;
        kind_next = kind_reg;
        if (accept) begin
            if (pos_eff == POS_HUNT) begin
                pos_next = (s_tdata == HDR_BYTE) ? POS_TYPE : POS_HUNT;
            end else if (pos_eff == POS_TYPE) begin
                if (s_tdata == TYPE_ACC || s_tdata == TYPE_GYRO) begin
                    kind_next = (s_tdata == TYPE_GYRO) ? KIND_GYRO : KIND_ACC;
                    pos_next  = POS_PAY_FIRST;
                end else begin
                    // re-examine the bad type byte as a header
                    pos_next = (s_tdata == HDR_BYTE) ? POS_TYPE : POS_HUNT;
                end
            end else if (pos_eff < POS_LAST) begin
                pos_next = pos_eff + 4'd1;
            end else begin
                pos_next = POS_HUNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HUNT;
            kind_reg <= KIND_ACC;
        end else begin
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pos_eff >= POS_PAY_FIRST && pos_eff < POS_LAST) begin
            pay_reg[pay_idx] <= s_tdata;
        end
    end

endmodule

### rtl/ifsd_queue.sv
// Two-entry frame queue between parser and scaling pipeline.
module ifsd_queue import ifsd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  frame_t    push_frame,
    input  logic      pop,
    output q_status_t q_status,
    output frame_t    pop_frame
);

    frame_t              ent_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign q_status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_status.valid = (cnt_reg != '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && q_status.valid;
    assign pop_frame      = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

### rtl/ifsd_back.sv
// Scaling pipeline: multiply stage, then shift/saturate/offset into the output register.
module ifsd_back import ifsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  q_status_t   q_status,
    input  frame_t      pop_frame,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic        m_tuser
);

    logic                      s1_valid_reg;
    logic                      s1_kind_reg;
    logic signed [PROD_W-1:0]  s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [TPROD_W-1:0]        s1_pt_reg;
    logic                      s1_tneg_reg;

    logic                      out_valid_reg;
    logic                      out_kind_reg;
    logic [OUT_W-1:0]          out_x_reg, out_y_reg, out_z_reg, out_t_reg;

    logic                      out_ready, s1_ready;
    logic signed [OUT_W-1:0]   axis_mult;
    logic                      t_neg;
    logic [RAW_W-1:0]          t_mag;
    logic [RAW_W-1:0]          t_quot;
    logic signed [OUT_W-1:0]   t_signed;

    function automatic logic [OUT_W-1:0] scale_out(logic signed [PROD_W-1:0] prod,
                                                   logic gyro);
        logic signed [PROD_W-1:0] v;
        v = gyro ? (prod >>> GYRO_SHIFT) : (prod >>> ACC_SHIFT);
        if (v > AXIS_LIM) begin
            v = AXIS_LIM;
        end else if (v < -AXIS_LIM) begin
            v = -AXIS_LIM;
        end
        return v[OUT_W-1:0];
    endfunction

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = q_status.valid && s1_ready;

    assign axis_mult = (pop_frame.kind == KIND_GYRO) ? GYRO_MULT : ACC_MULT;
    assign t_neg     = pop_frame.raw_t[RAW_W-1];
    assign t_mag     = t_neg ? RAW_W'(-pop_frame.raw_t) : pop_frame.raw_t;
    assign t_quot    = s1_pt_reg[TEMP_SHIFT +: RAW_W];
    assign t_signed  = s1_tneg_reg ? -$signed(OUT_W'(t_quot)) : $signed(OUT_W'(t_quot));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_status.valid;
            end
            if (out_ready) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_kind_reg <= pop_frame.kind;
            s1_px_reg   <= PROD_W'(pop_frame.raw_x) * PROD_W'(axis_mult);
            s1_py_reg   <= PROD_W'(pop_frame.raw_y) * PROD_W'(axis_mult);
            s1_pz_reg   <= PROD_W'(pop_frame.raw_z) * PROD_W'(axis_mult);
            s1_pt_reg   <= TPROD_W'(t_mag) * TPROD_W'(TEMP_RECIP);
            s1_tneg_reg <= t_neg;
        end
        if (out_ready && s1_valid_reg) begin
            out_kind_reg <= s1_kind_reg;
            out_x_reg    <= scale_out(s1_px_reg, s1_kind_reg);
            out_y_reg    <= scale_out(s1_py_reg, s1_kind_reg);
            out_z_reg    <= scale_out(s1_pz_reg, s1_kind_reg);
            out_t_reg    <= t_signed + TEMP_OFS;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'b0, out_t_reg, out_z_reg, out_y_reg, out_x_reg};

endmodule

### rtl/imu_frame_sync_decoder_unit.sv
// Top level of the IMU frame sync decoder: byte stream in, scaled frames out.
//
//  Channel | Direction | tdata (low bit up)                     | tuser
//  --------+-----------+----------------------------------------+------------
//  s_      | in        | data_byte[7:0]                         | -
//  m_      | out       | axis_x, axis_y, axis_z, temperature    | frame_kind
//          |           | (17 bits each, [67:0]; [71:68] zero)   |
//
//  Cycles: one byte transaction per clock while the result side keeps up.
//  After the eleventh byte a result passes the queue, the multiply stage, then
//  the output register with shift, saturation and temperature offset.
//  Reset: synchronous, active low; the parser returns to header hunt, queue and
//  pipeline empty. Payload bytes hold no reset value.
//  Stalls: m_tready low fills the output register, the multiply stage and the
//  two-entry queue; only then does s_tready drop, and only on a final frame byte.
module imu_frame_sync_decoder_unit import ifsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [16:0] axis_x, [33:17] axis_y, [50:34] axis_z,
                                    // [67:51] temperature, [71:68] zero
    output logic        m_tuser     // [0] frame_kind
);

    q_status_t q_status;
    logic      push, pop;
    frame_t    push_frame, pop_frame;

    // Front: hunt headers, check type, collect payload, hand over complete frames
    ifsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push       (push),
        .push_frame (push_frame)
    );

    // Decouple parser from scaling so either side can stall
    ifsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .q_status   (q_status),
        .pop_frame  (pop_frame)
    );

    // Back: scale axes and temperature, drive the result channel
    ifsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .pop_frame  (pop_frame),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### tb/imu_frame_sync_decoder_unit_tb.sv
// Self-checking testbench for the IMU frame sync decoder: byte stream in, scaled frames checked.
`timescale 1ns / 100ps

module imu_frame_sync_decoder_unit_tb;
    import ifsd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 130;
    localparam int PHASE_FRAMES  = 12;

    // One decoded frame as it appears on the result channel
    typedef struct packed {
        logic        kind;
        logic [16:0] axis_x;
        logic [16:0] axis_y;
        logic [16:0] axis_z;
        logic [16:0] temp;
    } scaled_frame_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;             // [16:0] x, [33:17] y, [50:34] z, [67:51] temp
    logic        m_tuser;             // [0] frame_kind

    // Shadow of the parser state, advanced on every accepted byte
    logic [3:0]  parse_pos;
    logic        latched_kind;
    logic [7:0]  pay_bytes [PAY_BYTES];

    scaled_frame_t frame_q [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    int          counted_bytes  = 0;
    int          frames_pushed  = 0;

    imu_frame_sync_decoder_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop: a hung handshake must not run forever
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: drop tready at random according to the current idle rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Scale one raw axis to Q8: floor via arithmetic shift, saturate angular rate
    function automatic logic [16:0] scale_axis_q8(input logic [15:0] raw, input logic gyro);
        longint prod;
        prod = longint'($signed(raw));
        if (gyro) begin
            prod = (prod * 125) >>> 3;
            if (prod > 64000)
                prod = 64000;
            if (prod < -64000)
                prod = -64000;
        end else begin
            prod = (prod * 40141) >>> 15;
        end
        return prod[16:0];
    endfunction

    // Temperature: truncate toward zero, then add the 36.25 degree offset
    function automatic logic [16:0] scale_temp_q8(input logic [15:0] raw);
        int tq;
        tq = int'($signed(raw));
        tq = (tq * 256) / 340 + 9280;
        return tq[16:0];
    endfunction

    // Advance the shadow parser by one byte; queue a frame on the final byte
    function automatic void decode_byte(input logic [7:0] b);
        logic [3:0]    pos;
        scaled_frame_t f;
        pos = parse_pos;
        if (pos > POS_LAST)
            pos = POS_HUNT;
        if (pos == POS_HUNT) begin
            parse_pos = (b == HDR_BYTE) ? POS_TYPE : POS_HUNT;
        end else if (pos == POS_TYPE) begin
            if (b == TYPE_ACC || b == TYPE_GYRO) begin
                latched_kind = (b == TYPE_GYRO) ? KIND_GYRO : KIND_ACC;
                parse_pos = POS_PAY_FIRST;
            end else begin
                // re-examine the bad type byte as a possible header
                parse_pos = (b == HDR_BYTE) ? POS_TYPE : POS_HUNT;
            end
        end else if (pos < POS_LAST) begin
            pay_bytes[pos - POS_PAY_FIRST] = b;
            parse_pos = pos + 4'd1;
        end else begin
            f.kind   = latched_kind;
            f.axis_x = scale_axis_q8({pay_bytes[1], pay_bytes[0]}, latched_kind);
            f.axis_y = scale_axis_q8({pay_bytes[3], pay_bytes[2]}, latched_kind);
            f.axis_z = scale_axis_q8({pay_bytes[5], pay_bytes[4]}, latched_kind);
            f.temp   = scale_temp_q8({pay_bytes[7], pay_bytes[6]});
            frame_q.push_back(f);
            frames_pushed++;
            parse_pos = POS_HUNT;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Checker: compare each result transaction with the oldest expected frame
    always @(posedge aclk) begin
        scaled_frame_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_q.size() == 0) begin
                report_mismatch("unexpected frame", m_tdata[16:0], 17'h0);
            end else begin
                want = frame_q.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("frame_kind", 17'(m_tuser), 17'(want.kind));
                if (m_tdata[16:0] != want.axis_x)
                    report_mismatch("axis_x", m_tdata[16:0], want.axis_x);
                if (m_tdata[33:17] != want.axis_y)
                    report_mismatch("axis_y", m_tdata[33:17], want.axis_y);
                if (m_tdata[50:34] != want.axis_z)
                    report_mismatch("axis_z", m_tdata[50:34], want.axis_z);
                if (m_tdata[67:51] != want.temp)
                    report_mismatch("temperature", m_tdata[67:51], want.temp);
                if (m_tdata[71:68] != 4'h0)
                    report_mismatch("tdata padding", 17'(m_tdata[71:68]), 17'h0);
            end
        end
    end

    // Send one byte: idle at random first, hold tvalid until the transaction completes.
    // tvalid is left high afterwards so back-to-back bytes never toggle it in one step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // bytes dropped while hunting do not count as stimulus
        if (parse_pos != POS_HUNT || b == HDR_BYTE)
            counted_bytes++;
        decode_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z,
                              input logic [15:0] t, input logic [7:0] tail);
        send_byte(HDR_BYTE);
        send_byte(ftype);
        send_byte(x[7:0]);
        send_byte(x[15:8]);
        send_byte(y[7:0]);
        send_byte(y[15:8]);
        send_byte(z[7:0]);
        send_byte(z[15:8]);
        send_byte(t[7:0]);
        send_byte(t[15:8]);
        send_byte(tail);
    endtask

    // Mix full-scale, saturation-edge and fully random raw values
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 8400) - 4200);
            default: return 16'($urandom);
        endcase
    endfunction

    // Bad type bytes: plain garbage drops to hunt, a repeated header waits for type
    task automatic test_bad_type_resync();
        send_byte(HDR_BYTE);
        send_byte(8'h13);
        send_byte(HDR_BYTE);
        send_frame(TYPE_GYRO, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, HDR_BYTE);
    endtask

    // Full-scale acceleration and the coldest temperature, ignored tail of all ones
    task automatic test_extreme_frames();
        send_frame(TYPE_ACC, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 8'hFF);
    endtask

    // Mostly well-formed frames with random content, some noise and broken headers
    task automatic test_random_frames(input int tx_pct, input int rx_pct);
        int sel;
        tx_idle_pct   = tx_pct;
        rx_idle_pct   = rx_pct;
        counted_bytes = 0;
        frames_pushed = 0;
        while (counted_bytes < PHASE_BYTES || frames_pushed < PHASE_FRAMES) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                send_frame((sel < 40) ? TYPE_ACC : TYPE_GYRO, pick_raw(), pick_raw(),
                           pick_raw(), pick_raw(), 8'($urandom));
            end else if (sel < 88) begin
                // broken header: the type byte is random, maybe another header
                send_byte(HDR_BYTE);
                send_byte(($urandom_range(0, 1) != 0) ? HDR_BYTE : 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        int waited;
        parse_pos    = POS_HUNT;
        latched_kind = KIND_ACC;
        foreach (pay_bytes[i])
            pay_bytes[i] = 8'h00;

        // hold reset, then release it once for the whole run
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 18;
        rx_idle_pct = 76;
        test_bad_type_resync();
        test_extreme_frames();

        test_random_frames(18, 76);
        test_random_frames(76, 18);
        test_random_frames(0, 0);

        // stop sending, then drain the pipeline
        s_tvalid <= 1'b0;
        waited = 0;
        while (frame_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (frame_q.size() != 0)
            report_mismatch("frames never delivered", 17'(frame_q.size()), 17'h0);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
